[rtl/frame_rate_monitor_macros.svh]
// Assertion macros for the frame rate monitor
`ifndef FRAME_RATE_MONITOR_MACROS_SVH
`define FRAME_RATE_MONITOR_MACROS_SVH

`ifndef NO_ASSERTIONS
`define FRM_ASSERT_SAME(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("frame_rate_monitor: same-cycle check failed");
`define FRM_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("frame_rate_monitor: next-cycle check failed");
`else
`define FRM_ASSERT_SAME(label, clk, rst_n, cond, prop)
`define FRM_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

[rtl/frm_pkg.sv]
// Shared types and constants of the frame rate monitor
package frm_pkg;

    localparam int FRAME_W  = 16;
    localparam int TOTAL_W  = 40;
    localparam int WIN_W    = 20;
    localparam int COUNT_W  = 16;
    localparam int WDONE_W  = 4;
    localparam int ACCUM_W  = 24;
    localparam int SMOOTH_W = 28;
    localparam int FRAC_W   = 8;
    localparam int DIVD_W   = ACCUM_W + FRAC_W;

    localparam logic [FRAME_W-1:0] WINDOW_MS_RESET = 16'd1000;
    localparam logic [WDONE_W-1:0] WPA_RESET       = 4'd10;

    localparam logic REG_WINDOW_MS = 1'b0;
    localparam logic REG_WPA       = 1'b1;

    typedef struct packed {
        logic               start;
        logic [ACCUM_W-1:0] accum;
        logic [ACCUM_W-1:0] frames;
    } frm_div_req_t;

    typedef struct packed {
        logic                done;
        logic [SMOOTH_W-1:0] quotient;
    } frm_div_rsp_t;

endpackage

[rtl/frm_div.sv]
// Bit-serial restoring divider for the Q8 average frame time
module frm_div (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  frm_pkg::frm_div_req_t req,
    output frm_pkg::frm_div_rsp_t rsp
);
    import frm_pkg::*;

    localparam int CNT_W = $clog2(DIVD_W);

    logic                busy_reg, busy_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [ACCUM_W-1:0]  rem_reg, rem_next;
    logic [DIVD_W-1:0]   dq_reg, dq_next;
    logic [ACCUM_W-1:0]  div_reg, div_next;
    logic                done_reg, done_next;
    logic [SMOOTH_W-1:0] quot_reg, quot_next;
    logic [ACCUM_W:0]    trial;
    logic                ge;

    always_comb begin
        trial     = {rem_reg, dq_reg[DIVD_W-1]};
        ge        = (trial >= {1'b0, div_reg});
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        div_next  = div_reg;
        done_next = 1'b0;
        quot_next = quot_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dq_next   = {req.accum, {FRAC_W{1'b0}}};
            div_next  = req.frames;
        end else if (busy_reg) begin
            rem_next = ge ? ACCUM_W'(trial - {1'b0, div_reg}) : trial[ACCUM_W-1:0];
            dq_next  = {dq_reg[DIVD_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIVD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (div_reg == '0) begin
                    quot_next = '0;
                end else if (dq_next[DIVD_W-1:SMOOTH_W] != '0) begin
                    quot_next = '1;
                end else begin
                    quot_next = dq_next[SMOOTH_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        rem_reg  <= rem_next;
        dq_reg   <= dq_next;
        div_reg  <= div_next;
        quot_reg <= quot_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

endmodule

[rtl/frame_rate_monitor.sv]
// Frame rate monitor top level: statistics update, sequencer and result register
// The result is registered: valid in the cycle after the input transfer, or, when an
// average is due, after the divider finishes and ST_DIV loads the result register.
// The divider gives one quotient bit per cycle over 32 bits; input stalls until m_ready.
// Synchronous active-low reset clears all statistics; window_ms = 1000, windows = 10.
`include "frame_rate_monitor_macros.svh"

module frame_rate_monitor (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_index,
    input  logic [frm_pkg::FRAME_W-1:0]     cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [frm_pkg::FRAME_W-1:0]     s_frame_ms,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [frm_pkg::FRAME_W-1:0]     m_delta_ms,
    output logic [frm_pkg::TOTAL_W-1:0]     m_total_ms,
    output logic [frm_pkg::COUNT_W-1:0]     m_fps_shown,
    output logic [frm_pkg::SMOOTH_W-1:0]    m_smooth_delta_q8,
    output logic                            m_smooth_valid
);
    import frm_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t              state_reg, state_next;
    logic [FRAME_W-1:0]  window_ms_reg, window_ms_next;
    logic [WDONE_W-1:0]  wpa_reg, wpa_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [WIN_W-1:0]    wtime_reg, wtime_next;
    logic [COUNT_W-1:0]  fiw_reg, fiw_next;
    logic [COUNT_W-1:0]  fps_reg, fps_next;
    logic [WDONE_W-1:0]  wdone_reg, wdone_next;
    logic [ACCUM_W-1:0]  accum_reg, accum_next;
    logic [ACCUM_W-1:0]  frames_reg, frames_next;
    logic [SMOOTH_W-1:0] smooth_reg, smooth_next;
    logic                have_avg_reg, have_avg_next;
    logic                m_valid_reg, m_valid_next;
    logic [FRAME_W-1:0]  delta_reg, delta_next;
    logic [SMOOTH_W-1:0] out_smooth_reg, out_smooth_next;
    logic                out_svalid_reg, out_svalid_next;

    logic [WIN_W:0]      wsum;
    logic [WIN_W-1:0]    wsat;
    logic                close_win;
    logic [WDONE_W:0]    wd_sum;
    logic [WDONE_W-1:0]  wd_sat;
    logic                avg_due;
    logic [ACCUM_W-1:0]  accum_base, frames_base;
    logic [ACCUM_W:0]    accum_sum, frames_sum;
    logic [COUNT_W:0]    fiw_sum;
    logic                in_xfer;

    frm_div_req_t div_req;
    frm_div_rsp_t div_rsp;

    frm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_xfer   = s_valid && s_ready;

    always_comb begin
        state_next      = state_reg;
        window_ms_next  = window_ms_reg;
        wpa_next        = wpa_reg;
        total_next      = total_reg;
        wtime_next      = wtime_reg;
        fiw_next        = fiw_reg;
        fps_next        = fps_reg;
        wdone_next      = wdone_reg;
        accum_next      = accum_reg;
        frames_next     = frames_reg;
        smooth_next     = smooth_reg;
        have_avg_next   = have_avg_reg;
        m_valid_next    = m_valid_reg;
        delta_next      = delta_reg;
        out_smooth_next = out_smooth_reg;
        out_svalid_next = out_svalid_reg;

        wsum       = {1'b0, wtime_reg} + {{(WIN_W - FRAME_W + 1){1'b0}}, s_frame_ms};
        wsat       = wsum[WIN_W] ? '1 : wsum[WIN_W-1:0];
        close_win  = (wsat >= {{(WIN_W - FRAME_W){1'b0}}, window_ms_reg});
        wd_sum     = {1'b0, wdone_reg} + 1'b1;
        wd_sat     = wd_sum[WDONE_W] ? '1 : wd_sum[WDONE_W-1:0];
        avg_due    = close_win && (wd_sat >= wpa_reg);
        fiw_sum    = {1'b0, fiw_reg} + 1'b1;
        accum_base = avg_due ? '0 : accum_reg;
        frames_base = avg_due ? '0 : frames_reg;
        accum_sum  = {1'b0, accum_base} +
                     {{(ACCUM_W - FRAME_W + 1){1'b0}}, s_frame_ms};
        frames_sum = {1'b0, frames_base} + 1'b1;

        div_req.start  = in_xfer && avg_due;
        div_req.accum  = accum_reg;
        div_req.frames = frames_reg;

        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_WINDOW_MS: window_ms_next = cfg_data;
                REG_WPA:       wpa_next = cfg_data[WDONE_W-1:0];
                default:       ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    total_next = total_reg + {{(TOTAL_W - FRAME_W){1'b0}}, s_frame_ms};
                    delta_next = s_frame_ms;
                    if (close_win) begin
                        wtime_next = '0;
                        fps_next   = fiw_reg;
                        fiw_next   = '0;
                        wdone_next = avg_due ? '0 : wd_sat;
                    end else begin
                        wtime_next = wsat;
                        fiw_next   = fiw_sum[COUNT_W] ? '1 : fiw_sum[COUNT_W-1:0];
                    end
                    accum_next  = accum_sum[ACCUM_W] ? '1 : accum_sum[ACCUM_W-1:0];
                    frames_next = frames_sum[ACCUM_W] ? '1 : frames_sum[ACCUM_W-1:0];
                    if (avg_due) begin
                        state_next = ST_DIV;
                    end else begin
                        out_smooth_next = have_avg_reg ? smooth_reg :
                            {{(SMOOTH_W - FRAME_W - FRAC_W){1'b0}}, s_frame_ms,
                             {FRAC_W{1'b0}}};
                        out_svalid_next = have_avg_reg;
                        m_valid_next    = 1'b1;
                        state_next      = ST_OUT;
                    end
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    smooth_next     = div_rsp.quotient;
                    have_avg_next   = 1'b1;
                    out_smooth_next = div_rsp.quotient;
                    out_svalid_next = 1'b1;
                    m_valid_next    = 1'b1;
                    state_next      = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            window_ms_reg  <= WINDOW_MS_RESET;
            wpa_reg        <= WPA_RESET;
            total_reg      <= '0;
            wtime_reg      <= '0;
            fiw_reg        <= '0;
            fps_reg        <= '0;
            wdone_reg      <= '0;
            accum_reg      <= '0;
            frames_reg     <= '0;
            smooth_reg     <= '0;
            have_avg_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            window_ms_reg  <= window_ms_next;
            wpa_reg        <= wpa_next;
            total_reg      <= total_next;
            wtime_reg      <= wtime_next;
            fiw_reg        <= fiw_next;
            fps_reg        <= fps_next;
            wdone_reg      <= wdone_next;
            accum_reg      <= accum_next;
            frames_reg     <= frames_next;
            smooth_reg     <= smooth_next;
            have_avg_reg   <= have_avg_next;
            m_valid_reg    <= m_valid_next;
        end
        delta_reg      <= delta_next;
        out_smooth_reg <= out_smooth_next;
        out_svalid_reg <= out_svalid_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_delta_ms        = delta_reg;
    assign m_total_ms        = total_reg;
    assign m_fps_shown       = fps_reg;
    assign m_smooth_delta_q8 = out_smooth_reg;
    assign m_smooth_valid    = out_svalid_reg;

    `FRM_ASSERT_SAME(a_out_blocks_in, aclk, aresetn, m_valid, !s_ready)
    `FRM_ASSERT_SAME(a_done_in_div, aclk, aresetn, div_rsp.done, state_reg == ST_DIV)
    `FRM_ASSERT_NEXT(a_start_to_div, aclk, aresetn, div_req.start, state_reg == ST_DIV)
    `FRM_ASSERT_NEXT(a_avg_sticks, aclk, aresetn, have_avg_reg, have_avg_reg)

endmodule

[tb/sv/frame_rate_monitor_tb.sv]
// Self-checking testbench for the frame rate monitor: directed and random frame streams against a predictor
`timescale 1ns / 100ps

module frame_rate_monitor_tb;
    import frm_pkg::*;

    typedef struct packed {
        logic [FRAME_W-1:0]  delta;
        logic [TOTAL_W-1:0]  total;
        logic [COUNT_W-1:0]  fps;
        logic [SMOOTH_W-1:0] smooth;
        logic                smooth_ok;
    } frame_stats_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic                cfg_index = REG_WINDOW_MS;
    logic [FRAME_W-1:0]  cfg_data = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [FRAME_W-1:0]  s_frame_ms = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [FRAME_W-1:0]  m_delta_ms;
    logic [TOTAL_W-1:0]  m_total_ms;
    logic [COUNT_W-1:0]  m_fps_shown;
    logic [SMOOTH_W-1:0] m_smooth_delta_q8;
    logic                m_smooth_valid;

    logic [FRAME_W-1:0]  pending_frames[$];
    frame_stats_t        expected_stats[$];

    logic [FRAME_W-1:0]  cfg_window_ms = WINDOW_MS_RESET;
    logic [WDONE_W-1:0]  cfg_windows = WPA_RESET;

    logic [TOTAL_W-1:0]  run_total = '0;
    logic [WIN_W-1:0]    window_elapsed = '0;
    logic [COUNT_W-1:0]  window_frames = '0;
    logic [COUNT_W-1:0]  shown_fps = '0;
    logic [WDONE_W-1:0]  windows_closed = '0;
    logic [ACCUM_W-1:0]  avg_sum = '0;
    logic [ACCUM_W-1:0]  avg_frames = '0;
    logic [SMOOTH_W-1:0] avg_q8 = '0;
    logic                avg_ready = 1'b0;

    bit                  quiet = 1'b0;
    bit                  hold_done = 1'b0;
    int                  hold_left = 0;
    int                  results_seen = 0;
    int                  mismatch_count = 0;

    frame_rate_monitor dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_frame_ms        (s_frame_ms),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_delta_ms        (m_delta_ms),
        .m_total_ms        (m_total_ms),
        .m_fps_shown       (m_fps_shown),
        .m_smooth_delta_q8 (m_smooth_delta_q8),
        .m_smooth_valid    (m_smooth_valid)
    );

    always #6 aclk = ~aclk;

    function void update_frame_stats(input logic [FRAME_W-1:0] d);
        logic [WIN_W:0]    win_sum;
        logic [ACCUM_W:0]  acc_sum;
        logic [DIVD_W-1:0] quot;
        frame_stats_t      res;
        run_total = run_total + d;
        win_sum = window_elapsed + d;
        window_elapsed = win_sum[WIN_W] ? '1 : win_sum[WIN_W-1:0];
        if (window_elapsed < cfg_window_ms) begin
            if (window_frames != '1) window_frames = window_frames + 1'b1;
        end else begin
            window_elapsed = '0;
            shown_fps = window_frames;
            window_frames = '0;
            if (windows_closed != '1) windows_closed = windows_closed + 1'b1;
            if (windows_closed >= cfg_windows) begin
                if (avg_frames == '0) quot = '0;
                else quot = {avg_sum, {FRAC_W{1'b0}}} / avg_frames;
                avg_q8 = (quot[DIVD_W-1:SMOOTH_W] != '0) ? '1 : quot[SMOOTH_W-1:0];
                avg_ready = 1'b1;
                avg_sum = '0;
                avg_frames = '0;
                windows_closed = '0;
            end
        end
        acc_sum = avg_sum + d;
        avg_sum = acc_sum[ACCUM_W] ? '1 : acc_sum[ACCUM_W-1:0];
        if (avg_frames != '1) avg_frames = avg_frames + 1'b1;
        res.delta = d;
        res.total = run_total;
        res.fps = shown_fps;
        res.smooth = avg_ready ? avg_q8 : {{(SMOOTH_W-FRAME_W-FRAC_W){1'b0}}, d, {FRAC_W{1'b0}}};
        res.smooth_ok = avg_ready;
        expected_stats.push_back(res);
    endfunction

    task report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("result %0d: %s got 0x%0h, expected 0x%0h", results_seen, what, got, want);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                update_frame_stats(s_frame_ms);
            if (!s_valid || s_ready) begin
                if (pending_frames.size() > 0 && (quiet || $urandom_range(99) >= 16)) begin
                    s_valid    <= 1'b1;
                    s_frame_ms <= pending_frames.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        frame_stats_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (hold_left > 0)
                hold_left--;
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_stats.size() == 0) begin
                    report_mismatch("transfer with nothing expected", m_delta_ms, 64'd0);
                end else begin
                    want = expected_stats.pop_front();
                    if (m_delta_ms !== want.delta)
                        report_mismatch("delta_ms", m_delta_ms, want.delta);
                    if (m_total_ms !== want.total)
                        report_mismatch("total_ms", m_total_ms, want.total);
                    if (m_fps_shown !== want.fps)
                        report_mismatch("fps_shown", m_fps_shown, want.fps);
                    if (m_smooth_delta_q8 !== want.smooth)
                        report_mismatch("smooth_delta_q8", m_smooth_delta_q8, want.smooth);
                    if (m_smooth_valid !== want.smooth_ok)
                        report_mismatch("smooth_valid", m_smooth_valid, want.smooth_ok);
                end
                if (results_seen == 150 && !hold_done) begin
                    hold_left = 400;
                    hold_done = 1'b1;
                end
            end
            m_ready <= (hold_left == 0) && (quiet || $urandom_range(99) >= 16);
        end
    end

    task write_register(input logic idx, input logic [FRAME_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_WINDOW_MS) cfg_window_ms = value;
        else cfg_windows = value[WDONE_W-1:0];
    endtask

    task wait_drained;
        while (pending_frames.size() != 0 || s_valid || expected_stats.size() != 0)
            @(posedge aclk);
    endtask

    function logic [FRAME_W-1:0] random_frame(input logic [FRAME_W-1:0] win);
        int r;
        r = $urandom_range(99);
        if (r < 80) return FRAME_W'($urandom_range(0, win / 4));
        if (r < 92) return FRAME_W'($urandom_range(0, win));
        return FRAME_W'($urandom);
    endfunction

    initial begin
        logic [FRAME_W-1:0] win;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        pending_frames = '{16'd0, 16'hFFFF, 16'd1, 16'd999, 16'd1, 16'h8000, 16'h7FFF,
                           16'hAAAA, 16'h5555};
        wait_drained();

        write_register(REG_WINDOW_MS, 16'd0);
        write_register(REG_WPA, 16'd0);
        pending_frames = '{16'd0, 16'd7, 16'hFFFF};
        wait_drained();

        write_register(REG_WINDOW_MS, 16'hFFFF);
        write_register(REG_WPA, 16'd15);
        pending_frames = '{16'hFFFF, 16'd0, 16'hFFFE, 16'd1};
        wait_drained();

        write_register(REG_WINDOW_MS, 16'd1);
        write_register(REG_WPA, 16'd1);
        pending_frames = '{16'd0, 16'd0, 16'd1, 16'd0, 16'd2, 16'd1};
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            case (p % 4)
                0: win = FRAME_W'($urandom_range(16, 256));
                1: win = FRAME_W'($urandom_range(1, 16));
                2: win = FRAME_W'($urandom_range(256, 4096));
                default: win = FRAME_W'($urandom);
            endcase
            quiet = (p == 5);
            write_register(REG_WINDOW_MS, win);
            write_register(REG_WPA, p == 0 ? 16'd15 : p == 1 ? 16'd1 :
                                    FRAME_W'($urandom_range(0, 15)));
            for (int n = 0; n < 90; n++)
                pending_frames.push_back(random_frame(win));
            wait_drained();
        end
        quiet = 1'b0;

        repeat (40) @(posedge aclk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #15_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
